FILE: hw/rtl/fepa_pkg.sv
package fepa_pkg;

	localparam int CFG_W       = 32;
	localparam int CFG_INDEX_W = 2;
	localparam int LOG_W       = 40;
	localparam int DIFF_W      = 41;
	localparam int MA_W        = 49;
	localparam int MB_W        = 18;
	localparam int PROD_W      = MA_W + MB_W;
	localparam int N_W         = 27;
	localparam int R_W         = 32;
	localparam int M_W         = 31;
	localparam int FRAC_W      = 16;
	localparam int LNK_W       = 6;
	localparam int LNR_W       = 23;
	localparam int E_W         = 17;
	localparam int SUM_W       = 65;
	localparam int EXP_WIDE    = 48;
	localparam int SQ_STEPS    = 16;
	localparam int HORNER_LAST = 4;

	localparam logic [CFG_INDEX_W-1:0] REG_BETA = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_KT   = 2'd1;

	localparam logic [CFG_W-1:0] BETA_RESET = 32'd26214;
	localparam logic [CFG_W-1:0] KT_RESET   = 32'd163027;

	localparam logic signed [MB_W-1:0] LOG2E_Q16   = 18'sd94548;
	localparam logic signed [MB_W-1:0] LN2_Q16     = 18'sd45426;
	localparam logic [R_W-1:0]         HORNER_SEED = 32'd1431680;
	localparam logic signed [N_W-1:0]  EXP_BIAS    = 27'sd14;

	typedef logic [4:0] op_t;

	localparam op_t OP_NONE   = 5'd0;
	localparam op_t OP_LOAD   = 5'd1;
	localparam op_t OP_PM_HI  = 5'd2;
	localparam op_t OP_PM_LO  = 5'd3;
	localparam op_t OP_SEED   = 5'd4;
	localparam op_t OP_MAX    = 5'd5;
	localparam op_t OP_EXP_Y  = 5'd6;
	localparam op_t OP_EXP_H  = 5'd7;
	localparam op_t OP_EXP_SH = 5'd8;
	localparam op_t OP_LN1    = 5'd9;
	localparam op_t OP_LN2    = 5'd10;
	localparam op_t OP_SQ     = 5'd11;
	localparam op_t OP_LN_FIN = 5'd12;
	localparam op_t OP_LS     = 5'd13;
	localparam op_t OP_DIFF   = 5'd14;
	localparam op_t OP_Q_HI   = 5'd15;
	localparam op_t OP_Q_LO   = 5'd16;
	localparam op_t OP_OUT    = 5'd17;

	typedef struct packed {
		op_t        op;
		logic [2:0] step;
		logic       phase;
	} fepa_cmd_t;

	typedef struct packed {
		logic seeded;
		logic out_busy;
	} fepa_status_t;

	function automatic logic [R_W-1:0] horner_coef(input logic [2:0] step);
		logic [R_W-1:0] c;
		unique case (step)
			3'd0: c = 32'd10327388;
			3'd1: c = 32'd59597083;
			3'd2: c = 32'd257941248;
			3'd3: c = 32'd744261118;
			3'd4: c = 32'd1073741824;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

FILE: hw/rtl/fepa_if.sv
interface fepa_frame_if;
	logic               valid;
	logic               ready;
	logic [31:0]        time_a;
	logic [31:0]        time_b;
	logic signed [31:0] energy_a;
	logic signed [31:0] energy_b;

	modport source(output valid, time_a, time_b, energy_a, energy_b, input ready);
	modport sink(input valid, time_a, time_b, energy_a, energy_b, output ready);
endinterface

interface fepa_result_if #(parameter int VALUE_WIDTH = 32);
	logic                          valid;
	logic                          ready;
	logic [31:0]                   frame_time;
	logic signed [VALUE_WIDTH-1:0] energy_delta;
	logic [VALUE_WIDTH-1:0]        boltzmann_weight;
	logic signed [VALUE_WIDTH-1:0] free_energy;
	logic                          time_mismatch_seen;

	modport source(output valid, frame_time, energy_delta, boltzmann_weight, free_energy,
		time_mismatch_seen, input ready);
	modport sink(input valid, frame_time, energy_delta, boltzmann_weight, free_energy,
		time_mismatch_seen, output ready);
endinterface

FILE: hw/rtl/fepa_controller.sv
module fepa_controller (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output fepa_pkg::fepa_cmd_t    cmd,
	input  fepa_pkg::fepa_status_t status
);
	import fepa_pkg::*;

	localparam logic [4:0] ST_IDLE   = 5'd0;
	localparam logic [4:0] ST_PM_HI  = 5'd1;
	localparam logic [4:0] ST_PM_LO  = 5'd2;
	localparam logic [4:0] ST_SEED   = 5'd3;
	localparam logic [4:0] ST_MAX    = 5'd4;
	localparam logic [4:0] ST_EXP_Y  = 5'd5;
	localparam logic [4:0] ST_EXP_H  = 5'd6;
	localparam logic [4:0] ST_EXP_SH = 5'd7;
	localparam logic [4:0] ST_LN1    = 5'd8;
	localparam logic [4:0] ST_LN2    = 5'd9;
	localparam logic [4:0] ST_SQ     = 5'd10;
	localparam logic [4:0] ST_LN_FIN = 5'd11;
	localparam logic [4:0] ST_LS     = 5'd12;
	localparam logic [4:0] ST_DIFF   = 5'd13;
	localparam logic [4:0] ST_Q_HI   = 5'd14;
	localparam logic [4:0] ST_Q_LO   = 5'd15;
	localparam logic [4:0] ST_OUT    = 5'd16;

	logic [4:0] state_q, state_n;
	logic [2:0] step_q, step_n;
	logic [3:0] sq_q, sq_n;
	logic       phase_q, phase_n;
	op_t        op;

	always_comb begin
		state_n  = state_q;
		step_n   = step_q;
		sq_n     = sq_q;
		phase_n  = phase_q;
		op       = OP_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op      = OP_LOAD;
					state_n = ST_PM_HI;
				end
			end
			ST_PM_HI: begin
				op      = OP_PM_HI;
				state_n = ST_PM_LO;
			end
			ST_PM_LO: begin
				op      = OP_PM_LO;
				state_n = status.seeded ? ST_MAX : ST_SEED;
			end
			ST_SEED: begin
				op      = OP_SEED;
				state_n = ST_IDLE;
			end
			ST_MAX: begin
				op      = OP_MAX;
				phase_n = 1'b0;
				state_n = ST_EXP_Y;
			end
			ST_EXP_Y: begin
				op      = OP_EXP_Y;
				step_n  = '0;
				state_n = ST_EXP_H;
			end
			ST_EXP_H: begin
				op = OP_EXP_H;
				if (step_q == 3'(HORNER_LAST)) begin
					state_n = ST_EXP_SH;
				end else begin
					step_n = step_q + 3'd1;
				end
			end
			ST_EXP_SH: begin
				op      = OP_EXP_SH;
				state_n = phase_q ? ST_OUT : ST_LN1;
			end
			ST_LN1: begin
				op      = OP_LN1;
				sq_n    = '0;
				state_n = ST_SQ;
			end
			ST_LN2: begin
				op      = OP_LN2;
				sq_n    = '0;
				state_n = ST_SQ;
			end
			ST_SQ: begin
				op = OP_SQ;
				if (sq_q == 4'(SQ_STEPS - 1)) begin
					state_n = ST_LN_FIN;
				end else begin
					sq_n = sq_q + 4'd1;
				end
			end
			ST_LN_FIN: begin
				op      = OP_LN_FIN;
				state_n = phase_q ? ST_DIFF : ST_LS;
			end
			ST_LS: begin
				op      = OP_LS;
				phase_n = 1'b1;
				state_n = ST_LN2;
			end
			ST_DIFF: begin
				op      = OP_DIFF;
				state_n = ST_Q_HI;
			end
			ST_Q_HI: begin
				op      = OP_Q_HI;
				state_n = ST_Q_LO;
			end
			ST_Q_LO: begin
				op      = OP_Q_LO;
				state_n = ST_EXP_Y;
			end
			ST_OUT: begin
				if (!status.out_busy) begin
					op      = OP_OUT;
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	assign cmd.op    = op;
	assign cmd.step  = step_q;
	assign cmd.phase = phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			sq_q    <= '0;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_n;
			step_q  <= step_n;
			sq_q    <= sq_n;
			phase_q <= phase_n;
		end
	end

endmodule

FILE: hw/rtl/fepa_datapath.sv
module fepa_datapath #(
	parameter int VALUE_WIDTH = 32,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  fepa_pkg::fepa_cmd_t                  cmd,
	output fepa_pkg::fepa_status_t               status,
	input  logic                                 cfg_write,
	input  logic [fepa_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [fepa_pkg::CFG_W-1:0]           cfg_data,
	input  logic [31:0]                          time_a,
	input  logic [31:0]                          time_b,
	input  logic signed [31:0]                   energy_a,
	input  logic signed [31:0]                   energy_b,
	input  logic                                 out_ready,
	output logic                                 out_valid,
	output logic [31:0]                          frame_time,
	output logic signed [VALUE_WIDTH-1:0]        energy_delta,
	output logic [VALUE_WIDTH-1:0]               boltzmann_weight,
	output logic signed [VALUE_WIDTH-1:0]        free_energy,
	output logic                                 time_mismatch_seen
);
	import fepa_pkg::*;

	localparam int VW = VALUE_WIDTH;
	localparam int CW = COUNT_WIDTH;
	localparam int KW = $clog2(CW);

	localparam logic signed [VW-1:0]    V_MAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0]    V_MIN = {1'b1, {(VW-1){1'b0}}};
	localparam logic [SUM_W-1:0]        V_LIM = SUM_W'(1) << (VW - 1);
	localparam logic signed [LOG_W-1:0] P_MAX = {1'b0, {(LOG_W-1){1'b1}}};
	localparam logic signed [LOG_W-1:0] P_MIN = {1'b1, {(LOG_W-1){1'b0}}};
	localparam logic [SUM_W-1:0]        P_LIM = SUM_W'(1) << (LOG_W - 1);
	localparam logic signed [N_W-1:0]   EXP_LIM_W = N_W'(VW - 16);
	localparam logic signed [N_W-1:0]   EXP_LIM_E = N_W'(EXP_WIDE - 16);

	logic [CFG_W-1:0]          beta_q, kt_q;
	logic                      seeded_q, mismatch_q, out_valid_q;
	logic signed [LOG_W-1:0]   log_sum_q;
	logic [CW-1:0]             cnt_q;
	logic [KW-1:0]             cntk_q;

	logic [31:0]               ta_q;
	logic signed [VW-1:0]      delta_q;
	logic [63:0]               t_q;
	logic signed [LOG_W-1:0]   p_q, mx_q;
	logic signed [DIFF_W-1:0]  arg_q;
	logic signed [N_W-1:0]     n_q;
	logic [FRAC_W-1:0]         f_q, frac_q;
	logic [R_W-1:0]            r_q;
	logic [E_W-1:0]            e_q;
	logic [VW-1:0]             w_q;
	logic [M_W-1:0]            m_q;
	logic [LNK_W-1:0]          lnk_q;
	logic [LNR_W-1:0]          lnres_q;
	logic [DIFF_W-1:0]         dm_q;
	logic                      dpos_q;
	logic signed [VW-1:0]      g_q;
	logic [31:0]               o_time_q;
	logic signed [VW-1:0]      o_delta_q, o_g_q;
	logic [VW-1:0]             o_w_q;
	logic                      o_mis_q;

	logic [VW-1:0]             dmag;
	logic signed [MA_W-1:0]    mul_a;
	logic signed [MB_W-1:0]    mul_b;
	logic signed [PROD_W-1:0]  mul_p;
	logic [SUM_W-1:0]          acc_sum;
	logic signed [48:0]        d_raw;
	logic signed [VW-1:0]      d_sat;
	logic signed [LOG_W-1:0]   p_sat, mx_n, mn_n;
	logic signed [N_W-1:0]     exp_lim, exp_amt_l, exp_amt_r;
	logic                      exp_sat;
	logic [63:0]               exp_val;
	logic [17:0]               sp_v;
	logic [CW+29:0]            cnt_ext;
	logic [2*M_W-1:0]          sq_p;
	logic [M_W:0]              sq;
	logic signed [LOG_W:0]     ls_sum;
	logic signed [LOG_W-1:0]   ls_sat;
	logic signed [DIFF_W-1:0]  diff;
	logic signed [VW-1:0]      g_sat;
	logic                      cnt_full, cnt_pow;

	assign dmag = delta_q[VW-1] ? VW'(-delta_q) : VW'(delta_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_PM_HI: begin
				mul_a = MA_W'(dmag);
				mul_b = MB_W'(beta_q[31:16]);
			end
			OP_PM_LO: begin
				mul_a = MA_W'(dmag);
				mul_b = MB_W'(beta_q[15:0]);
			end
			OP_EXP_Y: begin
				mul_a = cmd.phase ? MA_W'(p_q) : MA_W'(arg_q);
				mul_b = LOG2E_Q16;
			end
			OP_EXP_H: begin
				mul_a = MA_W'(r_q);
				mul_b = MB_W'(f_q);
			end
			OP_LN_FIN: begin
				mul_a = MA_W'({lnk_q, frac_q});
				mul_b = LN2_Q16;
			end
			OP_Q_HI: begin
				mul_a = MA_W'(dm_q);
				mul_b = MB_W'(kt_q[31:16]);
			end
			OP_Q_LO: begin
				mul_a = MA_W'(dm_q);
				mul_b = MB_W'(kt_q[15:0]);
			end
			default: ;
		endcase
		mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	assign acc_sum = {1'b0, t_q} + SUM_W'(mul_p[PROD_W-1:16]);

	always_comb begin
		d_raw = 49'(energy_b) - 49'(energy_a);
		if (d_raw > 49'(V_MAX)) begin
			d_sat = V_MAX;
		end else if (d_raw < 49'(V_MIN)) begin
			d_sat = V_MIN;
		end else begin
			d_sat = d_raw[VW-1:0];
		end

		if (delta_q > 0) begin
			p_sat = (acc_sum > P_LIM) ? P_MIN : LOG_W'(SUM_W'(0) - acc_sum);
		end else begin
			p_sat = (acc_sum > P_LIM - SUM_W'(1)) ? P_MAX : LOG_W'(acc_sum);
		end

		if (dpos_q) begin
			g_sat = (acc_sum > V_LIM) ? V_MIN : VW'(SUM_W'(0) - acc_sum);
		end else begin
			g_sat = (acc_sum > V_LIM - SUM_W'(1)) ? V_MAX : VW'(acc_sum);
		end

		mx_n = (log_sum_q > p_q) ? log_sum_q : p_q;
		mn_n = (log_sum_q > p_q) ? p_q : log_sum_q;

		exp_lim   = cmd.phase ? EXP_LIM_W : EXP_LIM_E;
		exp_sat   = n_q >= exp_lim;
		exp_amt_l = n_q - EXP_BIAS;
		exp_amt_r = EXP_BIAS - n_q;
		if (n_q >= EXP_BIAS) begin
			exp_val = 64'(r_q) << exp_amt_l[4:0];
		end else if (exp_amt_r > 27'sd31) begin
			exp_val = '0;
		end else begin
			exp_val = 64'(r_q) >> exp_amt_r[4:0];
		end

		sp_v    = 18'd65536 + 18'(e_q);
		cnt_ext = {cnt_q, 30'b0} >> cntk_q;
		sq_p    = m_q * m_q;
		sq      = sq_p[2*M_W-1:30];

		ls_sum = (LOG_W+1)'(mx_q) + (LOG_W+1)'(lnres_q);
		ls_sat = (ls_sum > (LOG_W+1)'(P_MAX)) ? P_MAX : ls_sum[LOG_W-1:0];

		diff = DIFF_W'(log_sum_q) - DIFF_W'(lnres_q);

		cnt_full = &cnt_q;
		cnt_pow  = (cnt_q & (cnt_q + CW'(1))) == '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q      <= BETA_RESET;
			kt_q        <= KT_RESET;
			seeded_q    <= 1'b0;
			mismatch_q  <= 1'b0;
			log_sum_q   <= '0;
			cnt_q       <= '0;
			cntk_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					REG_BETA: beta_q <= cfg_data;
					REG_KT:   kt_q   <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (cmd.op)
				OP_LOAD: begin
					if (time_a != time_b) begin
						mismatch_q <= 1'b1;
					end
				end
				OP_SEED: begin
					log_sum_q <= p_q;
					cnt_q     <= CW'(1);
					cntk_q    <= '0;
					seeded_q  <= 1'b1;
				end
				OP_LS: begin
					log_sum_q <= ls_sat;
					if (!cnt_full) begin
						cnt_q <= cnt_q + CW'(1);
						if (cnt_pow) begin
							cntk_q <= cntk_q + KW'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				ta_q    <= time_a;
				delta_q <= d_sat;
			end
			OP_PM_HI: t_q <= mul_p[63:0];
			OP_PM_LO: p_q <= p_sat;
			OP_MAX: begin
				mx_q  <= mx_n;
				arg_q <= DIFF_W'(mn_n) - DIFF_W'(mx_n);
			end
			OP_EXP_Y: begin
				n_q <= mul_p[32+N_W-1:32];
				f_q <= mul_p[31:16];
				r_q <= HORNER_SEED;
			end
			OP_EXP_H: r_q <= horner_coef(cmd.step) + mul_p[16+R_W-1:16];
			OP_EXP_SH: begin
				if (cmd.phase) begin
					w_q <= exp_sat ? '1 : exp_val[VW-1:0];
				end else begin
					e_q <= exp_sat ? '1 : exp_val[E_W-1:0];
				end
			end
			OP_LN1: begin
				m_q    <= sp_v[17] ? M_W'({sp_v, 13'b0}) : M_W'({sp_v, 14'b0});
				lnk_q  <= LNK_W'(sp_v[17]);
				frac_q <= '0;
			end
			OP_LN2: begin
				m_q    <= cnt_ext[M_W-1:0];
				lnk_q  <= LNK_W'(cntk_q);
				frac_q <= '0;
			end
			OP_SQ: begin
				if (sq[M_W]) begin
					m_q    <= sq[M_W:1];
					frac_q <= {frac_q[FRAC_W-2:0], 1'b1};
				end else begin
					m_q    <= sq[M_W-1:0];
					frac_q <= {frac_q[FRAC_W-2:0], 1'b0};
				end
			end
			OP_LN_FIN: lnres_q <= mul_p[16+LNR_W-1:16];
			OP_DIFF: begin
				dm_q   <= diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
				dpos_q <= !diff[DIFF_W-1] && (diff != '0);
			end
			OP_Q_HI: t_q <= mul_p[63:0];
			OP_Q_LO: g_q <= g_sat;
			OP_OUT: begin
				o_time_q  <= ta_q;
				o_delta_q <= delta_q;
				o_w_q     <= w_q;
				o_g_q     <= g_q;
				o_mis_q   <= mismatch_q;
			end
			default: ;
		endcase
	end

	assign status.seeded   = seeded_q;
	assign status.out_busy = out_valid_q && !out_ready;

	assign out_valid          = out_valid_q;
	assign frame_time         = o_time_q;
	assign energy_delta       = o_delta_q;
	assign boltzmann_weight   = o_w_q;
	assign free_energy        = o_g_q;
	assign time_mismatch_seen = o_mis_q;

endmodule

FILE: hw/rtl/free_energy_perturbation_accumulator.sv
// Free energy perturbation accumulator. Each frame transfer carries two time stamps and the
// energies of states A and B in Q16.16; the block keeps a running log-sum-exp of
// -(E_B - E_A)*beta and, for every frame after the first, returns the frame time, the energy
// difference, its Boltzmann weight and the running free energy difference, with a sticky flag
// for unequal time stamps. The first frame after reset only seeds the sum and returns nothing.
// One frame is handled at a time. Every frame after the seeding one runs on one shared
// multiplier that steps through the two exponential polynomials and on a 16-step squaring
// loop run once for each of the two logarithms. The result sits in an output register, so
// the next frame is accepted while it waits. The user must write beta and thermal_energy
// through the register port only while no frame is in flight; the block does not enforce it.
module free_energy_perturbation_accumulator #(
	parameter int VALUE_WIDTH = 32,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [fepa_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [fepa_pkg::CFG_W-1:0]       cfg_data,
	fepa_frame_if.sink                       frame,
	fepa_result_if.source                    result
);
	import fepa_pkg::*;

	fepa_cmd_t    cmd;
	fepa_status_t status;
	logic         in_ready;

	assign frame.ready = in_ready;

	fepa_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (frame.valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.status   (status)
	);

	fepa_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.status             (status),
		.cfg_write          (cfg_write),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.time_a             (frame.time_a),
		.time_b             (frame.time_b),
		.energy_a           (frame.energy_a),
		.energy_b           (frame.energy_b),
		.out_ready          (result.ready),
		.out_valid          (result.valid),
		.frame_time         (result.frame_time),
		.energy_delta       (result.energy_delta),
		.boltzmann_weight   (result.boltzmann_weight),
		.free_energy        (result.free_energy),
		.time_mismatch_seen (result.time_mismatch_seen)
	);

endmodule

FILE: tb/free_energy_perturbation_accumulator_test.sv
`timescale 1ns / 1ps

module free_energy_perturbation_accumulator_test;
	import fepa_pkg::*;

	typedef struct {
		logic [31:0]        time_a;
		logic [31:0]        time_b;
		logic signed [31:0] energy_a;
		logic signed [31:0] energy_b;
		bit                 drain;
	} frame_t;

	typedef struct {
		logic [31:0] frame_time;
		logic [31:0] energy_delta;
		logic [31:0] boltzmann_weight;
		logic [31:0] free_energy;
		logic        time_mismatch_seen;
	} fep_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_W-1:0]       cfg_data;

	fepa_frame_if      frame();
	fepa_result_if #(32) result();

	free_energy_perturbation_accumulator #(.VALUE_WIDTH(32), .COUNT_WIDTH(32)) u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .frame(frame.sink), .result(result.source)
	);

	frame_t      pending_frames[$];
	fep_result_t expected_results[$];

	logic [31:0]    beta_q;
	logic [31:0]    kt_q;
	longint         log_sum_q;
	longint unsigned count_q;
	bit             seeded_q;
	bit             mismatch_q;

	int unsigned src_idle;
	int unsigned snk_idle;
	int          errors;
	int          stall_cycles;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic longint sat_to(longint v, int w);
		longint lim;
		lim = (longint'(1) <<< (w - 1)) - 1;
		if (v > lim)
			return lim;
		if (v < -lim - 1)
			return -lim - 1;
		return v;
	endfunction

	function automatic longint unsigned magnitude(longint v);
		return v < 0 ? longint'(0) - v : v;
	endfunction

	function automatic longint unsigned exp_fixed(longint x, int w);
		longint          y;
		longint          n;
		longint          sh;
		longint unsigned f;
		longint unsigned r;
		y = (x * 94548) >>> 16;
		n = y >>> 16;
		f = y - n * 65536;
		r = 1431680;
		r = 10327388 + ((r * f) >> 16);
		r = 59597083 + ((r * f) >> 16);
		r = 257941248 + ((r * f) >> 16);
		r = 744261118 + ((r * f) >> 16);
		r = (longint'(1) << 30) + ((r * f) >> 16);
		if (n >= w - 16)
			return (longint'(1) << w) - 1;
		sh = n - 14;
		if (sh >= 0)
			return r << sh;
		if (-sh >= 63)
			return 0;
		return r >> (-sh);
	endfunction

	function automatic longint ln_fixed(longint unsigned v, int frac_bits);
		int              k;
		longint unsigned m;
		longint          frac;
		frac = 0;
		if (v == 0)
			return 0;
		k = 63;
		while (v[k] == 1'b0)
			k--;
		m = (k >= 30) ? (v >> (k - 30)) : (v << (30 - k));
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (longint'(1) << 31)) begin
				frac = frac | 1;
				m = m >> 1;
			end
		end
		return ((longint'(k - frac_bits) * 65536 + frac) * 45426) >>> 16;
	endfunction

	function automatic void accumulate_frame(frame_t fr);
		longint          delta;
		longint          p;
		longint          mx;
		longint          mn;
		longint          diff;
		longint          g;
		longint unsigned pm;
		longint unsigned e;
		longint unsigned dm;
		longint unsigned q;
		fep_result_t     res;
		if (fr.time_a != fr.time_b)
			mismatch_q = 1'b1;
		delta = sat_to(longint'(fr.energy_b) - longint'(fr.energy_a), 32);
		pm = (magnitude(delta) * longint'(beta_q)) >> 16;
		p = delta > 0 ? -longint'(pm) : longint'(pm);
		p = sat_to(p, LOG_W);
		if (!seeded_q) begin
			log_sum_q = p;
			count_q = 1;
			seeded_q = 1'b1;
			return;
		end
		mx = log_sum_q > p ? log_sum_q : p;
		mn = log_sum_q > p ? p : log_sum_q;
		e = exp_fixed(mn - mx, EXP_WIDE);
		log_sum_q = sat_to(mx + ln_fixed(65536 + e, 16), LOG_W);
		if (count_q < 64'hFFFF_FFFF)
			count_q++;
		diff = log_sum_q - ln_fixed(count_q, 0);
		dm = magnitude(diff);
		q = dm * longint'(kt_q >> 16) + ((dm * longint'(kt_q & 32'hFFFF)) >> 16);
		g = diff > 0 ? -longint'(q) : longint'(q);
		g = sat_to(g, 32);
		res.frame_time = fr.time_a;
		res.energy_delta = delta[31:0];
		res.boltzmann_weight = 32'(exp_fixed(p, 32));
		res.free_energy = g[31:0];
		res.time_mismatch_seen = mismatch_q;
		expected_results = {expected_results, res};
	endfunction

	task automatic report(string field, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", field, got, want, $time);
		errors++;
	endtask

	// driver: present pending frames, predict on each transfer
	always @(posedge clk or negedge arst_n) begin
		frame_t fr;
		if (!arst_n) begin
			frame.valid <= 1'b0;
			frame.time_a <= '0;
			frame.time_b <= '0;
			frame.energy_a <= '0;
			frame.energy_b <= '0;
		end else begin
			if (frame.valid && frame.ready) begin
				fr.time_a = frame.time_a;
				fr.time_b = frame.time_b;
				fr.energy_a = frame.energy_a;
				fr.energy_b = frame.energy_b;
				fr.drain = 1'b0;
				accumulate_frame(fr);
			end
			if (!frame.valid || frame.ready) begin
				if (pending_frames.size() > 0 && $urandom_range(99) >= src_idle &&
						!(pending_frames[0].drain && expected_results.size() != 0)) begin
					fr = pending_frames.pop_front();
					frame.valid <= 1'b1;
					frame.time_a <= fr.time_a;
					frame.time_b <= fr.time_b;
					frame.energy_a <= fr.energy_a;
					frame.energy_b <= fr.energy_b;
				end else begin
					frame.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		fep_result_t want;
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else begin
			result.ready <= ($urandom_range(99) >= snk_idle);
			if (result.valid && result.ready) begin
				if (expected_results.size() == 0) begin
					$display("unexpected result transfer at %0t", $time);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (result.frame_time !== want.frame_time)
						report("frame_time", result.frame_time, want.frame_time);
					if (result.energy_delta !== want.energy_delta)
						report("energy_delta", result.energy_delta, want.energy_delta);
					if (result.boltzmann_weight !== want.boltzmann_weight)
						report("boltzmann_weight", result.boltzmann_weight,
							want.boltzmann_weight);
					if (result.free_energy !== want.free_energy)
						report("free_energy", result.free_energy, want.free_energy);
					if (result.time_mismatch_seen !== want.time_mismatch_seen)
						report("time_mismatch_seen", 32'(result.time_mismatch_seen),
							32'(want.time_mismatch_seen));
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((frame.valid && frame.ready) || (result.valid && result.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= 20000) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_BETA)
			beta_q = val;
		else if (idx == REG_KT)
			kt_q = val;
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	function automatic void push_frame(logic [31:0] ta, logic [31:0] tb, logic [31:0] ea,
			logic [31:0] eb, bit drain);
		frame_t fr;
		fr.time_a = ta;
		fr.time_b = tb;
		fr.energy_a = ea;
		fr.energy_b = eb;
		fr.drain = drain;
		pending_frames = {pending_frames, fr};
	endfunction

	function automatic void push_random_frame();
		logic [31:0] t;
		logic [31:0] ea;
		logic [31:0] eb;
		logic signed [31:0] d;
		t = $urandom;
		ea = $urandom;
		d = $urandom;
		case ($urandom_range(9))
			0: eb = $urandom;
			1, 2: eb = ea + (d >>> $urandom_range(31, 20));
			default: begin
				ea = $signed(ea) >>> $urandom_range(24, 4);
				eb = ea + (d >>> $urandom_range(31, 8));
			end
		endcase
		push_frame(t, ($urandom_range(29) == 0) ? $urandom : t, ea, eb,
			$urandom_range(199) == 0);
	endfunction

	task automatic settle();
		while (pending_frames.size() != 0 || frame.valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	initial begin
		errors = 0;
		stall_cycles = 0;
		src_idle = 0;
		snk_idle = 0;
		beta_q = BETA_RESET;
		kt_q = KT_RESET;
		log_sum_q = 0;
		count_q = 0;
		seeded_q = 0;
		mismatch_q = 0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// seeding frame, then extremes
		push_frame(32'd0, 32'd0, 32'd0, 32'd0, 0);
		push_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0, 0);
		push_frame(32'd5, 32'd5, 32'h7FFF_FFFF, 32'h8000_0000, 0);
		push_frame(32'd6, 32'd6, 32'h8000_0000, 32'h7FFF_FFFF, 0);
		push_frame(32'd7, 32'd7, 32'h8000_0000, 32'h8000_0000, 0);
		push_frame(32'd8, 32'd8, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
		push_frame(32'd9, 32'd9, 32'd0, 32'd1, 0);
		push_frame(32'd10, 32'd10, 32'd0, 32'hFFFF_FFFF, 1);
		push_frame(32'd11, 32'd11, 32'h0001_0000, 32'h0000_8000, 0);
		push_frame(32'd12, 32'd12, 32'hFFF0_0000, 32'h0010_0000, 0);
		push_frame(32'd13, 32'd13, 32'h0010_0000, 32'hFFF0_0000, 0);
		push_frame(32'h5555_AAAA, 32'hAAAA_5555, 32'h5555_5555, 32'hAAAA_AAAA, 0);
		push_frame(32'd14, 32'd14, 32'h0000_1000, 32'h0000_2000, 0);
		settle();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(REG_BETA, 32'h0001_0000); write_reg(REG_KT, 32'h0001_0000); end
				1: begin write_reg(REG_BETA, 32'd0); write_reg(REG_KT, 32'hFFFF_FFFF); end
				2: begin write_reg(REG_BETA, 32'hFFFF_FFFF); write_reg(REG_KT, 32'd0); end
				3: begin
					write_reg(REG_BETA, $urandom);
					write_reg(REG_KT, $urandom);
					write_reg(2'd2, $urandom);
					write_reg(2'd3, $urandom);
				end
				4: begin write_reg(REG_BETA, 32'h0000_1000); write_reg(REG_KT, 32'h0010_0000); end
				default: begin write_reg(REG_BETA, BETA_RESET); write_reg(REG_KT, KT_RESET); end
			endcase
			end_writes();
			case (ph % 4)
				0: begin src_idle = 0; snk_idle = 0; end
				1: begin src_idle = 72; snk_idle = 0; end
				2: begin src_idle = 0; snk_idle = 72; end
				default: begin src_idle = 23; snk_idle = 23; end
			endcase
			for (int i = 0; i < 310; i++)
				push_random_frame();
			settle();
		end

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/fepa_pkg.sv
hw/rtl/fepa_if.sv
hw/rtl/fepa_controller.sv
hw/rtl/fepa_datapath.sv
hw/rtl/free_energy_perturbation_accumulator.sv
tb/free_energy_perturbation_accumulator_test.sv
